// ===== rtl/cmi_pkg.sv =====
// ----------------------------------------------------------------------------
// cmi_pkg
// Shared types and codes of the costmap inflation block.
// ----------------------------------------------------------------------------
package cmi_pkg;

    localparam logic [1:0] KIND_TABLE_WR = 2'd0;
    localparam logic [1:0] KIND_CELL_WR  = 2'd1;
    localparam logic [1:0] KIND_RUN      = 2'd2;
    localparam logic [1:0] KIND_CELL_RD  = 2'd3;

    localparam logic RES_READ = 1'b0;
    localparam logic RES_DONE = 1'b1;

    localparam logic [2:0] CFG_MAP_WIDTH    = 3'd0;
    localparam logic [2:0] CFG_MAP_HEIGHT   = 3'd1;
    localparam logic [2:0] CFG_RADIUS_CELLS = 3'd2;
    localparam logic [2:0] CFG_FILL_UNKNOWN = 3'd3;
    localparam logic [2:0] CFG_LETHAL_CODE  = 3'd4;
    localparam logic [2:0] CFG_UNKNOWN_CODE = 3'd5;

    localparam logic [8:0] RST_MAP_WIDTH    = 9'd256;
    localparam logic [8:0] RST_MAP_HEIGHT   = 9'd256;
    localparam logic [3:0] RST_RADIUS       = 4'd0;
    localparam logic       RST_INFLATE      = 1'b0;
    localparam logic [7:0] RST_LETHAL_CODE  = 8'd254;
    localparam logic [7:0] RST_UNKNOWN_CODE = 8'd255;

    localparam logic signed [8:0] SKIP_COST = -9'sd1;

    typedef struct packed {
        logic       wr_en;
        logic [7:0] value;
    } cmi_upd_t;

endpackage

// ===== rtl/cmi_cell_update.sv =====
// ----------------------------------------------------------------------------
// cmi_cell_update
// Compare unit that decides the new value of one window cell.
// ----------------------------------------------------------------------------
module cmi_cell_update (
    input  logic              [7:0] old_value,
    input  logic signed       [8:0] cost,
    input  logic              [7:0] unknown_code,
    input  logic                    fill_unknown,
    output cmi_pkg::cmi_upd_t       upd
);
    import cmi_pkg::*;

    logic [7:0] cost8;

    assign cost8 = cost[7:0];

    always_comb
    begin
        upd.value = cost8;
        if (cost == SKIP_COST)
        begin
            upd.wr_en = 1'b0;
        end
        else if (old_value == unknown_code)
        begin
            upd.wr_en = fill_unknown;
        end
        else
        begin
            upd.wr_en = (cost8 > old_value);
        end
    end

endmodule

// ===== rtl/cmi_cost_table.sv =====
// ----------------------------------------------------------------------------
// cmi_cost_table
// Cost table memory with a clearing pass to the skip code after reset.
// ----------------------------------------------------------------------------
module cmi_cost_table #(
    parameter int AW = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 we,
    input  logic        [AW-1:0] waddr,
    input  logic signed    [8:0] wdata,
    input  logic                 re,
    input  logic        [AW-1:0] raddr,
    output logic signed    [8:0] rdata,
    output logic                 busy
);
    import cmi_pkg::*;

    logic signed [8:0] mem [2**AW];
    logic [AW-1:0]     clr_cnt_reg;
    logic              busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
            busy_reg    <= 1'b1;
        end
        else if (busy_reg)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == {AW{1'b1}})
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            mem[clr_cnt_reg] <= SKIP_COST;
        end
        else if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

    assign busy = busy_reg;

endmodule

// ===== rtl/cmi_grid_store.sv =====
// ----------------------------------------------------------------------------
// cmi_grid_store
// Single-port grid memory with registered read data.
// ----------------------------------------------------------------------------
module cmi_grid_store #(
    parameter int AW = 16
) (
    input  logic          clk,
    input  logic          en,
    input  logic          we,
    input  logic [AW-1:0] addr,
    input  logic    [7:0] wdata,
    output logic    [7:0] rdata
);
    logic [7:0] mem [2**AW];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata <= mem[addr];
            end
        end
    end

endmodule

// ===== rtl/costmap_obstacle_inflation.sv =====
// ----------------------------------------------------------------------------
// costmap_obstacle_inflation
// In-place obstacle inflation of an occupancy grid, one cell per step.
// ----------------------------------------------------------------------------
// Input beats (in_valid/in_ready) carry one of four kinds: table write, cell
// write, run and cell read. Output beats (out_valid/out_ready) return read
// data or a run-done marker. Configuration is written through cfg_we,
// cfg_addr and cfg_data; the user must do so only while the block is idle,
// as the block itself does not enforce it. Table and cell writes are
// accepted back to back. A read passes through ST_RD_DATA and ST_RD_OUT
// and raises out_valid once the output register is free. A run reads every
// scanned cell and, for each lethal source, reads every window cell and
// writes it back when the update unit asks; the grid memory has one port, so
// read and write are separate. in_ready is low while a read or run is
// in progress. After reset the cost table is swept to the skip code, one
// entry a cycle, over all (2**ceil(log2(MAX_RADIUS+1)))**2 entries (256 by
// default), with in_ready low. A stalled output beat is held in the output
// register; table and cell writes are still accepted meanwhile, and a
// pending read or run waits for the register to free.
// ----------------------------------------------------------------------------
module costmap_obstacle_inflation #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int MAX_RADIUS = 15
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic        [1:0] kind,
    input  logic        [7:0] cell_x,
    input  logic        [7:0] cell_y,
    input  logic        [7:0] cell_data,
    input  logic        [3:0] table_dx,
    input  logic        [3:0] table_dy,
    input  logic signed [8:0] table_cost,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              result_kind,
    output logic        [7:0] read_value,
    input  logic              cfg_we,
    input  logic        [2:0] cfg_addr,
    input  logic        [8:0] cfg_data
);
    import cmi_pkg::*;

    localparam int XW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int YW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int RW  = (MAX_RADIUS > 0) ? $clog2(MAX_RADIUS + 1) : 1;
    localparam int MXY = (XW > YW) ? XW : YW;
    localparam int SW  = ((MXY > 8) ? MXY : 8) + 1;
    localparam int TW  = (RW > 4) ? RW : 4;
    localparam int GAW = XW + YW;
    localparam int TAW = 2 * RW;

    typedef enum logic [8:0] {
        ST_IDLE      = 9'b000000001,
        ST_RD_DATA   = 9'b000000010,
        ST_RD_OUT    = 9'b000000100,
        ST_SCAN_RD   = 9'b000001000,
        ST_SCAN_CHK  = 9'b000010000,
        ST_WIN_SETUP = 9'b000100000,
        ST_WIN_RD    = 9'b001000000,
        ST_WIN_WR    = 9'b010000000,
        ST_DONE      = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    logic [8:0] map_width_reg, map_height_reg;
    logic [3:0] radius_cells_reg;
    logic       fill_unknown_reg;
    logic [7:0] lethal_code_reg, unknown_code_reg;

    logic [SW-1:0] scan_col_reg, scan_col_next, scan_row_reg, scan_row_next;
    logic [SW-1:0] win_col_reg, win_col_next, win_row_reg, win_row_next;
    logic [SW-1:0] x0_reg, x0_next, x1_reg, x1_next, y1_reg, y1_next;

    logic       out_valid_reg, out_valid_next;
    logic       result_kind_reg, result_kind_next;
    logic [7:0] read_value_reg, read_value_next;
    logic [7:0] read_hold_reg, read_hold_next;
    logic       rd_hit_reg, rd_hit_next;

    logic [SW-1:0] wu, hu, wm1, hm1, rad;
    logic [SW-1:0] x0_c, x1_c, y0_c, y1_c, xe, ye;
    logic [SW-1:0] adx, ady, cxe, cye;
    logic [SW-1:0] adv_col, adv_row;
    logic          scan_end;
    logic [TW-1:0] tdxe, tdye;

    logic          accept, in_store, slot_free, clear_busy;
    logic          grid_en, grid_we;
    logic [GAW-1:0] grid_addr;
    logic [7:0]    grid_wdata, grid_rdata;
    logic          tab_we;
    logic signed [8:0] tab_rdata;
    cmi_upd_t      upd;

    assign accept    = in_valid && in_ready;
    assign in_ready  = (state_reg == ST_IDLE) && !clear_busy;
    assign slot_free = !out_valid_reg || out_ready;

    assign cxe      = SW'(cell_x);
    assign cye      = SW'(cell_y);
    assign in_store = (cxe < SW'(MAX_WIDTH)) && (cye < SW'(MAX_HEIGHT));
    assign tdxe     = TW'(table_dx);
    assign tdye     = TW'(table_dy);

    assign wu  = (SW'(map_width_reg) > SW'(MAX_WIDTH)) ? SW'(MAX_WIDTH) : SW'(map_width_reg);
    assign hu  = (SW'(map_height_reg) > SW'(MAX_HEIGHT)) ?
                 SW'(MAX_HEIGHT) : SW'(map_height_reg);
    assign wm1 = wu - SW'(1);
    assign hm1 = hu - SW'(1);
    assign rad = (SW'(radius_cells_reg) > SW'(MAX_RADIUS)) ?
                 SW'(MAX_RADIUS) : SW'(radius_cells_reg);

    assign xe   = scan_col_reg + rad;
    assign ye   = scan_row_reg + rad;
    assign x0_c = (scan_col_reg > rad) ? scan_col_reg - rad : '0;
    assign y0_c = (scan_row_reg > rad) ? scan_row_reg - rad : '0;
    assign x1_c = (xe > wm1) ? wm1 : xe;
    assign y1_c = (ye > hm1) ? hm1 : ye;

    assign adx = (win_col_reg > scan_col_reg) ? win_col_reg - scan_col_reg
                                              : scan_col_reg - win_col_reg;
    assign ady = (win_row_reg > scan_row_reg) ? win_row_reg - scan_row_reg
                                              : scan_row_reg - win_row_reg;

    always_comb
    begin
        if (scan_col_reg == wm1)
        begin
            adv_col  = '0;
            adv_row  = scan_row_reg + SW'(1);
            scan_end = (scan_row_reg == hm1);
        end
        else
        begin
            adv_col  = scan_col_reg + SW'(1);
            adv_row  = scan_row_reg;
            scan_end = 1'b0;
        end
    end

    assign tab_we = accept && (kind == KIND_TABLE_WR)
                    && (TW'(table_dx) <= TW'(MAX_RADIUS) || MAX_RADIUS > 15)
                    && (TW'(table_dy) <= TW'(MAX_RADIUS) || MAX_RADIUS > 15);

    always_comb
    begin
        grid_en    = 1'b0;
        grid_we    = 1'b0;
        grid_addr  = {win_row_reg[YW-1:0], win_col_reg[XW-1:0]};
        grid_wdata = upd.value;
        case (state_reg)
            ST_IDLE:
            begin
                grid_addr  = {cye[YW-1:0], cxe[XW-1:0]};
                grid_wdata = cell_data;
                if (accept && (kind == KIND_CELL_WR) && in_store)
                begin
                    grid_en = 1'b1;
                    grid_we = 1'b1;
                end
                else if (accept && (kind == KIND_CELL_RD))
                begin
                    grid_en = 1'b1;
                end
            end
            ST_SCAN_RD:
            begin
                grid_en   = 1'b1;
                grid_addr = {scan_row_reg[YW-1:0], scan_col_reg[XW-1:0]};
            end
            ST_WIN_RD:
            begin
                grid_en = 1'b1;
            end
            ST_WIN_WR:
            begin
                grid_en = upd.wr_en;
                grid_we = upd.wr_en;
            end
            default:
            begin
                grid_en = 1'b0;
            end
        endcase
    end

    cmi_grid_store #(
        .AW (GAW)
    ) u_grid (
        .clk   (clk),
        .en    (grid_en),
        .we    (grid_we),
        .addr  (grid_addr),
        .wdata (grid_wdata),
        .rdata (grid_rdata)
    );

    cmi_cost_table #(
        .AW (TAW)
    ) u_table (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (tab_we),
        .waddr ({tdye[RW-1:0], tdxe[RW-1:0]}),
        .wdata (table_cost),
        .re    (state_reg == ST_WIN_RD),
        .raddr ({ady[RW-1:0], adx[RW-1:0]}),
        .rdata (tab_rdata),
        .busy  (clear_busy)
    );

    cmi_cell_update u_update (
        .old_value    (grid_rdata),
        .cost         (tab_rdata),
        .unknown_code (unknown_code_reg),
        .fill_unknown (fill_unknown_reg),
        .upd          (upd)
    );

    always_comb
    begin
        state_next       = state_reg;
        scan_col_next    = scan_col_reg;
        scan_row_next    = scan_row_reg;
        win_col_next     = win_col_reg;
        win_row_next     = win_row_reg;
        x0_next          = x0_reg;
        x1_next          = x1_reg;
        y1_next          = y1_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        result_kind_next = result_kind_reg;
        read_value_next  = read_value_reg;
        read_hold_next   = read_hold_reg;
        rd_hit_next      = rd_hit_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (kind == KIND_RUN))
                begin
                    scan_col_next = '0;
                    scan_row_next = '0;
                    if ((wu == '0) || (hu == '0))
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_SCAN_RD;
                    end
                end
                else if (accept && (kind == KIND_CELL_RD))
                begin
                    rd_hit_next = in_store;
                    state_next  = ST_RD_DATA;
                end
            end
            ST_RD_DATA:
            begin
                read_hold_next = rd_hit_reg ? grid_rdata : 8'd0;
                state_next     = ST_RD_OUT;
            end
            ST_RD_OUT:
            begin
                if (slot_free)
                begin
                    out_valid_next   = 1'b1;
                    result_kind_next = RES_READ;
                    read_value_next  = read_hold_reg;
                    state_next       = ST_IDLE;
                end
            end
            ST_SCAN_RD:
            begin
                state_next = ST_SCAN_CHK;
            end
            ST_SCAN_CHK:
            begin
                if (grid_rdata == lethal_code_reg)
                begin
                    state_next = ST_WIN_SETUP;
                end
                else
                begin
                    scan_col_next = adv_col;
                    scan_row_next = adv_row;
                    state_next    = scan_end ? ST_DONE : ST_SCAN_RD;
                end
            end
            ST_WIN_SETUP:
            begin
                x0_next      = x0_c;
                x1_next      = x1_c;
                y1_next      = y1_c;
                win_col_next = x0_c;
                win_row_next = y0_c;
                state_next   = ST_WIN_RD;
            end
            ST_WIN_RD:
            begin
                state_next = ST_WIN_WR;
            end
            ST_WIN_WR:
            begin
                state_next = ST_WIN_RD;
                if (win_col_reg == x1_reg)
                begin
                    win_col_next = x0_reg;
                    if (win_row_reg == y1_reg)
                    begin
                        win_col_next  = '0;
                        win_row_next  = '0;
                        scan_col_next = adv_col;
                        scan_row_next = adv_row;
                        state_next    = scan_end ? ST_DONE : ST_SCAN_RD;
                    end
                    else
                    begin
                        win_row_next = win_row_reg + SW'(1);
                    end
                end
                else
                begin
                    win_col_next = win_col_reg + SW'(1);
                end
            end
            ST_DONE:
            begin
                scan_col_next = '0;
                scan_row_next = '0;
                if (slot_free)
                begin
                    out_valid_next   = 1'b1;
                    result_kind_next = RES_DONE;
                    read_value_next  = 8'd0;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            out_valid_reg    <= 1'b0;
            scan_col_reg     <= '0;
            scan_row_reg     <= '0;
            win_col_reg      <= '0;
            win_row_reg      <= '0;
            map_width_reg    <= RST_MAP_WIDTH;
            map_height_reg   <= RST_MAP_HEIGHT;
            radius_cells_reg <= RST_RADIUS;
            fill_unknown_reg <= RST_INFLATE;
            lethal_code_reg  <= RST_LETHAL_CODE;
            unknown_code_reg <= RST_UNKNOWN_CODE;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            scan_col_reg  <= scan_col_next;
            scan_row_reg  <= scan_row_next;
            win_col_reg   <= win_col_next;
            win_row_reg   <= win_row_next;
            if (cfg_we)
            begin
                case (cfg_addr)
                    CFG_MAP_WIDTH:    map_width_reg    <= cfg_data;
                    CFG_MAP_HEIGHT:   map_height_reg   <= cfg_data;
                    CFG_RADIUS_CELLS: radius_cells_reg <= cfg_data[3:0];
                    CFG_FILL_UNKNOWN: fill_unknown_reg <= cfg_data[0];
                    CFG_LETHAL_CODE:  lethal_code_reg  <= cfg_data[7:0];
                    CFG_UNKNOWN_CODE: unknown_code_reg <= cfg_data[7:0];
                    default:          map_width_reg    <= map_width_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        x0_reg          <= x0_next;
        x1_reg          <= x1_next;
        y1_reg          <= y1_next;
        result_kind_reg <= result_kind_next;
        read_value_reg  <= read_value_next;
        read_hold_reg   <= read_hold_next;
        rd_hit_reg      <= rd_hit_next;
    end

    assign out_valid   = out_valid_reg;
    assign result_kind = result_kind_reg;
    assign read_value  = read_value_reg;

`ifndef SYNTHESIS
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clear_busy |-> !in_ready)
        else $error("input beat taken during table clear");

    a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (result_kind == RES_DONE)) |-> (read_value == 8'd0))
        else $error("run-done beat carries nonzero data");

    a_grid_write_src: assert property (@(posedge clk) disable iff (!rst_n)
        grid_we |-> ((state_reg == ST_IDLE) || (state_reg == ST_WIN_WR)))
        else $error("grid written outside a cell write or window update");

    a_run_start: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (kind == KIND_RUN)) |=>
        ((state_reg == ST_SCAN_RD) || (state_reg == ST_DONE)))
        else $error("run beat did not start a scan");
`endif

endmodule

// ===== bench/costmap_obstacle_inflation_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// costmap_obstacle_inflation_test
// Self-checking bench for the in-place costmap inflation block.
// ----------------------------------------------------------------------------
// A scoreboard class keeps its own copy of the grid, the cost table and the
// registers, predicts each read value and run-done beat, and checks the
// output beats in order. Stimulus opens with a short directed part on a
// small map, then moves through many register settings. Each setting
// writes each not yet written cell of its map, then mixes table and cell
// writes, reads and runs, with random input gaps and random output stalls.
// ----------------------------------------------------------------------------
module costmap_obstacle_inflation_test;
    import cmi_pkg::*;

    typedef struct {
        logic        [1:0] kind;
        logic        [7:0] x;
        logic        [7:0] y;
        logic        [7:0] data;
        logic        [3:0] dx;
        logic        [3:0] dy;
        logic signed [8:0] cost;
    } beat_t;

    typedef struct {
        logic       kind;
        logic [7:0] value;
    } outcome_t;

    class inflation_scoreboard;
        bit   [7:0]        grid [65536];
        logic signed [8:0] cost_lut [256];
        logic [8:0]        width_reg;
        logic [8:0]        height_reg;
        logic [3:0]        radius_reg;
        logic              inflate_reg;
        logic [7:0]        lethal_reg;
        logic [7:0]        unknown_reg;
        outcome_t          pending_results [$];
        int                mismatches;
        int                reads_checked;
        int                runs_checked;

        function new();
            foreach (cost_lut[i])
                cost_lut[i] = SKIP_COST;
            width_reg   = RST_MAP_WIDTH;
            height_reg  = RST_MAP_HEIGHT;
            radius_reg  = RST_RADIUS;
            inflate_reg = RST_INFLATE;
            lethal_reg  = RST_LETHAL_CODE;
            unknown_reg = RST_UNKNOWN_CODE;
            mismatches    = 0;
            reads_checked = 0;
            runs_checked  = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [8:0] data);
            case (idx)
                CFG_MAP_WIDTH:    width_reg   = data;
                CFG_MAP_HEIGHT:   height_reg  = data;
                CFG_RADIUS_CELLS: radius_reg  = data[3:0];
                CFG_FILL_UNKNOWN: inflate_reg = data[0];
                CFG_LETHAL_CODE:  lethal_reg  = data[7:0];
                CFG_UNKNOWN_CODE: unknown_reg = data[7:0];
                default: ;
            endcase
        endfunction

        function void spread_cost(int cx, int cy, int w, int h, int r);
            int                x0;
            int                x1;
            int                y0;
            int                y1;
            int                adx;
            int                ady;
            int                addr;
            logic signed [8:0] c;
            logic        [7:0] c8;
            x0 = (cx > r) ? cx - r : 0;
            y0 = (cy > r) ? cy - r : 0;
            x1 = (cx + r > w - 1) ? w - 1 : cx + r;
            y1 = (cy + r > h - 1) ? h - 1 : cy + r;
            for (int yy = y0; yy <= y1; yy++)
            begin
                for (int xx = x0; xx <= x1; xx++)
                begin
                    adx  = (xx > cx) ? xx - cx : cx - xx;
                    ady  = (yy > cy) ? yy - cy : cy - yy;
                    c    = cost_lut[ady * 16 + adx];
                    addr = yy * 256 + xx;
                    if (c != SKIP_COST)
                    begin
                        c8 = c[7:0];
                        if (grid[addr] == unknown_reg)
                        begin
                            if (inflate_reg)
                                grid[addr] = c8;
                        end
                        else if (c8 > grid[addr])
                            grid[addr] = c8;
                    end
                end
            end
        endfunction

        function void inflate_grid();
            int w;
            int h;
            w = (width_reg > 256) ? 256 : int'(width_reg);
            h = (height_reg > 256) ? 256 : int'(height_reg);
            for (int row = 0; row < h; row++)
            begin
                for (int col = 0; col < w; col++)
                begin
                    if (grid[row * 256 + col] == lethal_reg)
                        spread_cost(col, row, w, h, int'(radius_reg));
                end
            end
        endfunction

        function void note_beat(beat_t b);
            outcome_t o;
            case (b.kind)
                KIND_TABLE_WR: cost_lut[{b.dy, b.dx}] = b.cost;
                KIND_CELL_WR:  grid[{b.y, b.x}] = b.data;
                KIND_RUN:
                begin
                    inflate_grid();
                    o.kind  = RES_DONE;
                    o.value = 8'd0;
                    pending_results.push_back(o);
                end
                default:
                begin
                    o.kind  = RES_READ;
                    o.value = grid[{b.y, b.x}];
                    pending_results.push_back(o);
                end
            endcase
        endfunction

        function void check_beat(logic k, logic [7:0] v);
            outcome_t o;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected beat result_kind=%0d read_value=%0d", k, v);
            end
            else
            begin
                o = pending_results.pop_front();
                if (o.kind == RES_DONE)
                    runs_checked++;
                else
                    reads_checked++;
                if (k !== o.kind || v !== o.value)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: result_kind exp %0d got %0d, read_value exp %0d got %0d",
                                 o.kind, k, o.value, v);
                end
            end
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic        [1:0] kind;
    logic        [7:0] cell_x;
    logic        [7:0] cell_y;
    logic        [7:0] cell_data;
    logic        [3:0] table_dx;
    logic        [3:0] table_dy;
    logic signed [8:0] table_cost;
    logic              out_valid;
    logic              out_ready;
    logic              result_kind;
    logic        [7:0] read_value;
    logic              cfg_we;
    logic        [2:0] cfg_addr;
    logic        [8:0] cfg_data;

    inflation_scoreboard sb = new();

    bit written [65536];
    int written_list [$];
    int beats_sent     = 0;
    int burst_left     = 0;
    int settings_used  = 0;
    bit tx_idle        = 0;
    int rx_mode        = 0;

    costmap_obstacle_inflation uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .kind        (kind),
        .cell_x      (cell_x),
        .cell_y      (cell_y),
        .cell_data   (cell_data),
        .table_dx    (table_dx),
        .table_dy    (table_dy),
        .table_cost  (table_cost),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .result_kind (result_kind),
        .read_value  (read_value),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #40_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // output side: check at the rising edge, stall at the falling edge
    initial
    begin
        int hold;
        int tick;
        hold = 0;
        tick = 0;
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
                sb.check_beat(result_kind, read_value);
            @(negedge clk);
            tick++;
            case (rx_mode)
                0: out_ready <= 1'b1;
                1: out_ready <= ($urandom_range(0, 3) != 0);
                2: out_ready <= ((tick % 8) >= 3);
                default:
                begin
                    if (hold > 0)
                    begin
                        hold--;
                        out_ready <= 1'b0;
                    end
                    else if ($urandom_range(0, 15) == 0)
                    begin
                        hold = $urandom_range(5, 20);
                        out_ready <= 1'b0;
                    end
                    else
                        out_ready <= 1'b1;
                end
            endcase
        end
    end

    task automatic idle_cycles(int n);
        repeat (n)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
    endtask

    task automatic push_beat(beat_t b);
        if (burst_left == 0)
        begin
            if (tx_idle)
                idle_cycles($urandom_range(1, 6));
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        @(negedge clk);
        in_valid   <= 1'b1;
        kind       <= b.kind;
        cell_x     <= b.x;
        cell_y     <= b.y;
        cell_data  <= b.data;
        table_dx   <= b.dx;
        table_dy   <= b.dy;
        table_cost <= b.cost;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_beat(b);
        beats_sent++;
        if (b.kind == KIND_CELL_WR && !written[{b.y, b.x}])
        begin
            written[{b.y, b.x}] = 1'b1;
            written_list.push_back(int'({b.y, b.x}));
        end
    endtask

    function automatic beat_t random_beat(logic [1:0] k);
        beat_t b;
        b.kind = k;
        b.x    = 8'($urandom);
        b.y    = 8'($urandom);
        b.data = 8'($urandom);
        b.dx   = 4'($urandom);
        b.dy   = 4'($urandom);
        b.cost = 9'($urandom);
        return b;
    endfunction

    task automatic send_table(int dx, int dy, logic signed [8:0] c);
        beat_t b;
        b      = random_beat(KIND_TABLE_WR);
        b.dx   = dx[3:0];
        b.dy   = dy[3:0];
        b.cost = c;
        push_beat(b);
    endtask

    task automatic send_cell(int x, int y, logic [7:0] d);
        beat_t b;
        b      = random_beat(KIND_CELL_WR);
        b.x    = x[7:0];
        b.y    = y[7:0];
        b.data = d;
        push_beat(b);
    endtask

    task automatic send_read(int x, int y);
        beat_t b;
        b   = random_beat(KIND_CELL_RD);
        b.x = x[7:0];
        b.y = y[7:0];
        push_beat(b);
    endtask

    task automatic send_run();
        push_beat(random_beat(KIND_RUN));
    endtask

    task automatic send_read_any();
        int a;
        if (written_list.size() != 0)
        begin
            a = written_list[$urandom_range(0, written_list.size() - 1)];
            send_read(a % 256, a / 256);
        end
    endtask

    task automatic drain_results();
        while (sb.pending_results.size() != 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        idle_cycles(8);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [8:0] data);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= data;
        sb.set_reg(idx, data);
    endtask

    task automatic apply_settings(logic [8:0] w, logic [8:0] h, logic [8:0] r,
                                  logic [8:0] inf, logic [8:0] leth, logic [8:0] unk);
        write_reg(CFG_MAP_WIDTH, w);
        write_reg(CFG_MAP_HEIGHT, h);
        write_reg(CFG_RADIUS_CELLS, r);
        write_reg(CFG_FILL_UNKNOWN, inf);
        write_reg(CFG_LETHAL_CODE, leth);
        write_reg(CFG_UNKNOWN_CODE, unk);
        @(negedge clk);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    function automatic logic [7:0] cell_value(int leth, int unk, bit sparse);
        int p;
        p = $urandom_range(0, 99);
        if (p < (sparse ? 4 : 20))
            return leth[7:0];
        if (p < 35)
            return unk[7:0];
        if (p < 42)
            return 8'd0;
        if (p < 48)
            return 8'd255;
        return 8'($urandom);
    endfunction

    function automatic logic signed [8:0] table_entry(int leth);
        int p;
        p = $urandom_range(0, 99);
        if (p < 25)
            return SKIP_COST;
        if (p < 32)
            return 9'($urandom_range(0, 254) - 256);
        if (p < 40)
            return {1'b0, leth[7:0]};
        if (p < 45)
            return 9'sd255;
        if (p < 48)
            return 9'sd0;
        return 9'($urandom_range(0, 255));
    endfunction

    task automatic directed_part();
        apply_settings(9'd4, 9'd3, 9'd2, 9'd1, 9'd254, 9'd255);
        send_table(0, 0, 9'sd253);
        send_table(1, 0, 9'sd128);
        send_table(0, 1, SKIP_COST);
        send_table(1, 1, -9'sd2);
        send_table(2, 0, 9'sd255);
        send_table(2, 2, 9'sd0);
        send_table(0, 2, -9'sd256);
        send_table(15, 15, 9'sd100);
        send_cell(0, 0, 8'd254);
        send_cell(1, 0, 8'd0);
        send_cell(2, 0, 8'd100);
        send_cell(3, 0, 8'd255);
        send_cell(0, 1, 8'd255);
        send_cell(1, 1, 8'd50);
        send_cell(2, 1, 8'd7);
        send_cell(3, 1, 8'd0);
        send_cell(0, 2, 8'd10);
        send_cell(1, 2, 8'd255);
        send_cell(2, 2, 8'd20);
        send_cell(3, 2, 8'd254);
        send_run();
        send_read(1, 1);
        send_read(3, 2);
        send_read(0, 2);
    endtask

    task automatic random_phase(int n);
        int         w;
        int         h;
        int         r;
        int         inf;
        int         leth;
        int         unk;
        int         cw;
        int         ch;
        int         steps;
        int         pick;
        bit         big;
        logic [8:0] junk;
        drain_results();
        tx_idle = ($urandom_range(0, 3) != 0);
        rx_mode = $urandom_range(0, 3);
        w = $urandom_range(1, 8);
        h = $urandom_range(1, 8);
        case (n)
            1:  begin w = 256; h = 1;   end
            3:  begin w = 1;   h = 256; end
            5:  w = 0;
            7:  begin w = 300; h = 1;   end
            9:  begin w = 1;   h = 511; end
            11: h = 0;
            default: ;
        endcase
        case (n % 5)
            0: r = 15;
            1: r = 0;
            default: r = $urandom_range(0, 15);
        endcase
        inf  = $urandom_range(0, 1);
        leth = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : 254;
        unk  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : 255;
        if (n == 4)
            leth = 0;
        if (n == 6)
            leth = 255;
        if (n == 8 || n == 12)
            unk = leth;
        if (n == 10)
            unk = 0;
        junk = 9'($urandom);
        if ($urandom_range(0, 1) == 0)
            junk = 9'd0;
        apply_settings(w[8:0], h[8:0], {junk[8:4], r[3:0]}, {junk[8:1], inf[0]},
                       {junk[8], leth[7:0]}, {junk[0], unk[7:0]});

        cw  = (w > 256) ? 256 : w;
        ch  = (h > 256) ? 256 : h;
        big = (cw * ch > 64);
        for (int y = 0; y < ch; y++)
        begin
            for (int x = 0; x < cw; x++)
            begin
                if (!written[y * 256 + x])
                    send_cell(x, y, cell_value(leth, unk, big));
            end
        end
        repeat ($urandom_range(3, 10))
            send_table($urandom_range(0, r), $urandom_range(0, r), table_entry(leth));

        steps = big ? 15 : $urandom_range(20, 45);
        repeat (steps)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 24 && cw > 0 && ch > 0)
                send_cell($urandom_range(0, cw - 1), $urandom_range(0, ch - 1),
                          cell_value(leth, unk, big));
            else if (pick < 30)
                send_cell($urandom_range(0, 255), $urandom_range(0, 255), 8'($urandom));
            else if (pick < 42)
                send_table($urandom_range(0, r), $urandom_range(0, r), table_entry(leth));
            else if (pick < 50)
                send_table($urandom_range(0, 15), $urandom_range(0, 15), 9'($urandom));
            else if (pick < 88)
                send_read_any();
            else if (pick < 93)
                send_run();
            else if (pick < 95)
                drain_results();
            else
                send_read_any();
        end
        send_run();
        repeat ($urandom_range(3, 6))
            send_read_any();
    endtask

    initial
    begin
        int phase;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        kind       = KIND_TABLE_WR;
        cell_x     = 8'd0;
        cell_y     = 8'd0;
        cell_data  = 8'd0;
        table_dx   = 4'd0;
        table_dy   = 4'd0;
        table_cost = 9'sd0;
        cfg_we     = 1'b0;
        cfg_addr   = CFG_MAP_WIDTH;
        cfg_data   = 9'd0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        // hold until the table sweep after reset is done
        do
            @(posedge clk);
        while (!in_ready);

        directed_part();
        phase = 0;
        while (beats_sent < 1150)
        begin
            random_phase(phase);
            phase++;
        end

        drain_results();
        idle_cycles(40);
        $display("Covered %0d input beats across %0d register settings.",
                 beats_sent, settings_used);
        $display("Checked %0d inflation runs and %0d cell reads, %0d mismatches.",
                 sb.runs_checked, sb.reads_checked, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending_results.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
